@@ src/ilb_pkg.sv @@
// shared types and constants for the indexed list buffer
// no dependencies; imported by every module of the block

package ilb_pkg;

   localparam int DATA_W       = 32;
   localparam int POS_W        = 7;
   localparam int COUNT_W      = 7;
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [2:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_CLEAR  = 3'd2,
      ACT_INSERT = 3'd3,
      ACT_ERASE  = 3'd4,
      ACT_READ   = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]              action;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       count;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_INS_SHIFT,
      S_INS_PUT,
      S_ERS_SHIFT,
      S_RD_WAIT,
      S_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } count_op_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LAST,
      IDX_NEXT,
      IDX_POS,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_TAIL,
      WR_POS,
      WR_UP,
      WR_DOWN
   } wr_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         latch_status;
      logic         capture_rd;
      logic         load_rsp;
      logic         mem_we;
      wr_sel_type   wr_sel;
      count_op_type count_op;
      idx_op_type   idx_op;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       ok;
      logic       ins_at_end;
      logic       ers_at_last;
      logic       idx_at_pos;
      logic       idx_at_last;
   } dp_stat_type;

endpackage

@@ src/ilb_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on ilb_pkg for default sizes

module ilb_ram import ilb_pkg::*; #(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = CAPACITY_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ilb_datapath.sv @@
// datapath: item and result registers, entry count, shift index and the entry ram
// depends on ilb_pkg and ilb_ram; driven by ilb_control commands

module ilb_datapath import ilb_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

   req_type         op_ff, op_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   status_type      status_ff, status_in;
   rsp_type         rsp_ff, rsp_in;

   logic [CMP_W-1:0] pos_x, cnt_x, idx_x;
   logic             is_full, is_empty;
   status_type       status_code;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;

   assign pos_x    = CMP_W'(op_ff.position);
   assign cnt_x    = CMP_W'(count_ff);
   assign idx_x    = CMP_W'(idx_ff);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // full check ranks above the index check for insert
   always_comb begin
      status_code = ST_OK;
      case (op_ff.action)
         ACT_PUSH: begin
            if (is_full) status_code = ST_FULL;
         end
         ACT_POP: begin
            if (is_empty) status_code = ST_EMPTY;
         end
         ACT_INSERT: begin
            if (is_full) status_code = ST_FULL;
            else if (pos_x > cnt_x) status_code = ST_RANGE;
         end
         ACT_ERASE, ACT_READ: begin
            if (pos_x >= cnt_x) status_code = ST_RANGE;
         end
         default: status_code = ST_OK;
      endcase
   end

   always_comb begin
      stat.action      = op_ff.action;
      stat.ok          = (status_code == ST_OK);
      stat.ins_at_end  = (pos_x == cnt_x);
      stat.ers_at_last = (pos_x + 1'b1 == cnt_x);
      stat.idx_at_pos  = (idx_x == pos_x);
      stat.idx_at_last = (idx_x + 1'b1 == cnt_x);
   end

   always_comb begin
      op_in     = cmd.load_req ? req_data : op_ff;
      status_in = cmd.latch_status ? status_code : status_ff;
      rd_in     = rd_ff;
      if (cmd.load_req) begin
         rd_in = '0;
      end else if (cmd.capture_rd) begin
         rd_in = rd_data;
      end

      case (cmd.count_op)
         CNT_INC:   count_in = count_ff + 1'b1;
         CNT_DEC:   count_in = count_ff - 1'b1;
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase

      case (cmd.idx_op)
         IDX_LAST: idx_in = AW'(count_ff - 1'b1);
         IDX_NEXT: idx_in = AW'(pos_x + 1'b1);
         IDX_POS:  idx_in = AW'(op_ff.position);
         IDX_DEC:  idx_in = idx_ff - 1'b1;
         IDX_INC:  idx_in = idx_ff + 1'b1;
         default:  idx_in = idx_ff;
      endcase

      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.read_value = rd_ff;
         rsp_in.count      = COUNT_W'(count_ff);
         rsp_in.status     = status_ff;
      end
   end

   // shifts move one entry per cycle: read ahead at idx_in, write behind from idx_ff
   always_comb begin
      wr_en = cmd.mem_we;
      case (cmd.wr_sel)
         WR_POS: begin
            wr_addr = AW'(op_ff.position);
            wr_data = op_ff.value;
         end
         WR_UP: begin
            wr_addr = idx_ff + 1'b1;
            wr_data = rd_data;
         end
         WR_DOWN: begin
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data;
         end
         default: begin
            wr_addr = AW'(count_ff);
            wr_data = op_ff.value;
         end
      endcase
   end

   ilb_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

@@ src/ilb_control.sv @@
// controller state machine: sequences each item and owns the handshake flags
// depends on ilb_pkg; steers ilb_datapath through a command struct

module ilb_control import ilb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (stat.ok) begin
               case (stat.action)
                  ACT_INSERT: if (!stat.ins_at_end) state_in = S_INS_SHIFT;
                  ACT_ERASE:  if (!stat.ers_at_last) state_in = S_ERS_SHIFT;
                  ACT_READ:   state_in = S_RD_WAIT;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_INS_SHIFT: begin
            if (stat.idx_at_pos) state_in = S_INS_PUT;
         end
         S_INS_PUT: state_in = S_DONE;
         S_ERS_SHIFT: begin
            if (stat.idx_at_last) state_in = S_DONE;
         end
         S_RD_WAIT: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load_req     = 1'b0;
      cmd.latch_status = 1'b0;
      cmd.capture_rd   = 1'b0;
      cmd.load_rsp     = 1'b0;
      cmd.mem_we       = 1'b0;
      cmd.wr_sel       = WR_TAIL;
      cmd.count_op     = CNT_HOLD;
      cmd.idx_op       = IDX_HOLD;
      req_ready        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            cmd.latch_status = 1'b1;
            if (stat.ok) begin
               case (stat.action)
                  ACT_PUSH: begin
                     cmd.mem_we   = 1'b1;
                     cmd.wr_sel   = WR_TAIL;
                     cmd.count_op = CNT_INC;
                  end
                  ACT_POP:   cmd.count_op = CNT_DEC;
                  ACT_CLEAR: cmd.count_op = CNT_CLEAR;
                  ACT_INSERT: begin
                     if (stat.ins_at_end) begin
                        cmd.mem_we   = 1'b1;
                        cmd.wr_sel   = WR_POS;
                        cmd.count_op = CNT_INC;
                     end else begin
                        cmd.idx_op = IDX_LAST;
                     end
                  end
                  ACT_ERASE: begin
                     if (stat.ers_at_last) cmd.count_op = CNT_DEC;
                     else cmd.idx_op = IDX_NEXT;
                  end
                  ACT_READ: cmd.idx_op = IDX_POS;
                  default:  cmd.count_op = CNT_HOLD;
               endcase
            end
         end
         S_INS_SHIFT: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = WR_UP;
            if (!stat.idx_at_pos) cmd.idx_op = IDX_DEC;
         end
         S_INS_PUT: begin
            cmd.mem_we   = 1'b1;
            cmd.wr_sel   = WR_POS;
            cmd.count_op = CNT_INC;
         end
         S_ERS_SHIFT: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = WR_DOWN;
            if (stat.idx_at_last) cmd.count_op = CNT_DEC;
            else cmd.idx_op = IDX_INC;
         end
         S_RD_WAIT: cmd.capture_rd = 1'b1;
         S_DONE:    cmd.load_rsp = out_free;
         default:   cmd.load_req = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/indexed_list_buffer.sv @@
// top level of the indexed list buffer: bounded ordered list of signed words
// depends on ilb_pkg, ilb_control, ilb_datapath (which holds ilb_ram)
//
//   port group   dir   handshake              payload
//   req_         in    req_valid / req_ready  req_data  (action, position, value)
//   rsp_         out   rsp_valid / rsp_ready  rsp_data  (read_value, count, status)
//
// one item at a time. push, pop, clear, a refused item or an unknown action go
// straight to the result, a read waits for the ram data, and insert and erase
// first shift the entries past the position, one entry per cycle through the
// ram's single write port. the next item is taken once the result is loaded into
// the output register. reset clears the count and the handshake flags only;
// entries need no clearing. a result held in the output register by a low
// rsp_ready lets the next item be accepted and worked on up to its result.

module indexed_list_buffer import ilb_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   ilb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ilb_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
